>>> rtl/fbba_pkg.sv
// ----------------------------------------------------------------------------
// fbba_pkg: shared types and constants of the free block bitmap allocator
// Holds the map geometry, the request and response payloads, the status
// codes and the reset contents of one bitmap word.
// ----------------------------------------------------------------------------
package fbba_pkg;

  // Map geometry.
  localparam int MAP_BYTES       = 1024;
  localparam int RESERVED_BLOCKS = 18;
  localparam int BITS_PER_BYTE   = 8;
  localparam int MAX_BLOCKS      = 8192;
  localparam int RAW_BLOCKS      = MAP_BYTES * BITS_PER_BYTE;
  localparam int NUM_BLOCKS      = (RAW_BLOCKS < MAX_BLOCKS) ? RAW_BLOCKS : MAX_BLOCKS;

  localparam int WORD_BITS = 64;
  localparam int MAP_WORDS = 128;
  localparam int BIT_W     = $clog2(WORD_BITS);
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int BLK_W     = 13;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAP_WORDS - 1);
  localparam logic [BLK_W:0]    NUM_BLK   = (BLK_W + 1)'(NUM_BLOCKS);
  localparam logic [BLK_W:0]    RSV_BLK   = (BLK_W + 1)'(RESERVED_BLOCKS);

  // Request types.
  localparam logic REQ_ALLOC   = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  // Response status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic             req_type;
    logic [BLK_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [BLK_W-1:0] granted_block;
  } rsp_t;

  // Bitmap read and write port controls.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } map_rd_t;

  typedef struct packed {
    logic                 en;
    logic [ADDR_W-1:0]    addr;
    logic [WORD_BITS-1:0] data;
  } map_wr_t;

  // Result of the shared bit unit.
  typedef struct packed {
    logic                 found;
    logic [BIT_W-1:0]     first;
    logic [WORD_BITS-1:0] new_word;
  } bit_res_t;

  // Contents of a bitmap word after reset: a block is free when it lies
  // above the reserved range and inside the map.
  function automatic logic [WORD_BITS-1:0] word_reset(input logic [ADDR_W-1:0] w);
    logic [WORD_BITS-1:0] word;
    logic [BLK_W:0]       blk;
    word = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      blk     = {1'b0, w, BIT_W'(i)};
      word[i] = (blk >= RSV_BLK) && (blk < NUM_BLK);
    end
    return word;
  endfunction

endpackage

>>> rtl/fbba_bitmap.sv
// ----------------------------------------------------------------------------
// fbba_bitmap: free block bitmap storage
// One write port and one registered read port. Each word has a valid bit
// cleared by reset; a word never written reads as its reset contents.
// ----------------------------------------------------------------------------
module fbba_bitmap
  import fbba_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  map_rd_t              rd,
  input  map_wr_t              wr,
  output logic [WORD_BITS-1:0] rd_word
);

  logic [WORD_BITS-1:0] mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] valid;
  logic [WORD_BITS-1:0] rd_data;
  logic                 rd_valid;
  logic [ADDR_W-1:0]    rd_addr;

  // Storage array.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Per-word written flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr.en) begin
      valid[wr.addr] <= 1'b1;
    end
  end

  // Registered read.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rd_data  <= mem[rd.addr];
      rd_valid <= valid[rd.addr];
      rd_addr  <= rd.addr;
    end
  end

  assign rd_word = rd_valid ? rd_data : word_reset(rd_addr);

endmodule

>>> rtl/fbba_bit_unit.sv
// ----------------------------------------------------------------------------
// fbba_bit_unit: shared bitmap word unit
// Finds the lowest free bit of a word and builds the updated word: the
// chosen bit is cleared for an allocation or set for a release.
// ----------------------------------------------------------------------------
module fbba_bit_unit
  import fbba_pkg::*;
(
  input  logic [WORD_BITS-1:0] word,
  input  logic                 release_op,
  input  logic [BIT_W-1:0]     bit_sel,
  output bit_res_t             res
);

  logic [BIT_W-1:0]     first;
  logic [BIT_W-1:0]     target;
  logic [WORD_BITS-1:0] mask;

  // Priority encoder: lowest set bit wins.
  always_comb begin
    first = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) begin
        first = BIT_W'(i);
      end
    end
  end

  // Update the selected bit.
  assign target = release_op ? bit_sel : first;
  assign mask   = {{(WORD_BITS - 1){1'b0}}, 1'b1} << target;

  assign res.found    = |word;
  assign res.first    = first;
  assign res.new_word = release_op ? (word | mask) : (word & ~mask);

endmodule

>>> rtl/free_block_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// free_block_bitmap_allocator: first-fit block allocator on a bitmap
// Allocates the lowest free block or releases a named block in a
// 128 x 64 bit map where a 1 marks a free block.
//
//   Channel | Signals                  | Payload
//   --------+--------------------------+----------------------------------
//   request | req_valid, req_stall     | req: req_type, block_number
//   reply   | rsp_valid, rsp_stall     | rsp: status, granted_block
//
// An allocate scans one bitmap word per cycle through the single read port
// until it finds a free bit or reaches the last word without one; a release
// takes one read, one write and one reply load, and an out-of-range release
// skips the read and the write. One request is in work at a time. Reset
// brings up the map at once through per-word valid flags. A stalled reply
// holds in the output register; a finished request then waits until that register frees up.
// ----------------------------------------------------------------------------
module free_block_bitmap_allocator
  import fbba_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_REL  = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0]           state;
  logic [ADDR_W-1:0]    cur_addr;
  logic [BIT_W-1:0]     bit_sel;
  rsp_t                 result;
  map_rd_t              rd;
  map_wr_t              wr;
  logic [WORD_BITS-1:0] map_word;
  bit_res_t             unit;
  logic                 accept;
  logic                 is_release;
  logic                 out_of_range;
  logic                 slot_free;

  fbba_bitmap u_bitmap (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .wr      (wr),
    .rd_word (map_word)
  );

  fbba_bit_unit u_bit_unit (
    .word       (map_word),
    .release_op (state == S_REL),
    .bit_sel    (bit_sel),
    .res        (unit)
  );

  assign req_stall    = (state != S_IDLE);
  assign accept       = req_valid && !req_stall;
  assign is_release   = (req.req_type == REQ_RELEASE);
  assign out_of_range = ({1'b0, req.block_number} >= NUM_BLK);
  assign slot_free    = !rsp_valid || !rsp_stall;

  // Bitmap port control.
  always_comb begin
    rd.en   = 1'b0;
    rd.addr = cur_addr;
    wr.en   = 1'b0;
    wr.addr = cur_addr;
    wr.data = unit.new_word;
    case (state)
      S_IDLE: begin
        if (accept) begin
          rd.en   = !(is_release && out_of_range);
          rd.addr = is_release ? req.block_number[BLK_W-1:BIT_W] : '0;
        end
      end
      S_SCAN: begin
        if (unit.found) begin
          wr.en = 1'b1;
        end else if (cur_addr != LAST_ADDR) begin
          rd.en   = 1'b1;
          rd.addr = ADDR_W'(cur_addr + 1'b1);
        end
      end
      S_REL: begin
        wr.en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur_addr <= is_release ? req.block_number[BLK_W-1:BIT_W] : '0;
            bit_sel  <= req.block_number[BIT_W-1:0];
            result.granted_block <= '0;
            if (!is_release) begin
              state <= S_SCAN;
            end else if (out_of_range) begin
              result.status <= ST_RANGE;
              state         <= S_RESP;
            end else begin
              state <= S_REL;
            end
          end
        end
        S_SCAN: begin
          if (unit.found) begin
            result.status        <= ST_OK;
            result.granted_block <= {cur_addr, unit.first};
            state                <= S_RESP;
          end else if (cur_addr == LAST_ADDR) begin
            result.status        <= ST_FULL;
            result.granted_block <= '0;
            state                <= S_RESP;
          end else begin
            cur_addr <= ADDR_W'(cur_addr + 1'b1);
          end
        end
        S_REL: begin
          result.status <= ST_OK;
          state         <= S_RESP;
        end
        S_RESP: begin
          if (slot_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Reply output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == S_RESP && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RESP && slot_free) begin
      rsp <= result;
    end
  end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the free block bitmap allocator
// Sends allocate and release requests with random gaps against a randomly
// stalled reply channel. A shadow bitmap predicts every reply, and each reply
// is checked field by field in order. The run covers the reset contents of
// the map, reserved blocks, repeated releases, the extremes of the block
// number, and random traffic with balanced and allocation-heavy mixes.
// ----------------------------------------------------------------------------
module testbench
  import fbba_pkg::*;
();

  localparam int HANG_LIMIT  = 2000;
  localparam int SETTLE_CYC  = 20;
  localparam int SPARSE_REQS = 200;
  localparam int CHURN_REQS  = 250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  // Shadow of the free map: bit b of word w is block w * 64 + b, 1 = free.
  logic [WORD_BITS-1:0] shadow_words [MAP_WORDS];

  rsp_t owed_replies [$];
  int   errors = 0;
  int   grants = 0;
  int   full_replies = 0;
  int   releases = 0;
  int   idle_cycles = 0;

  free_block_bitmap_allocator dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Random idle length: mostly none or short, now and then long.
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Bring the shadow map to its state after reset.
  task automatic clear_shadow();
    for (int w = 0; w < MAP_WORDS; w++) shadow_words[w] = '0;
    for (int b = RESERVED_BLOCKS; b < NUM_BLOCKS; b++) begin
      shadow_words[b / WORD_BITS][b % WORD_BITS] = 1'b1;
    end
  endtask

  // Apply one request to the shadow map and return the reply it should get.
  function automatic rsp_t serve_request(input req_t r);
    rsp_t o;
    bit   found;
    int   w;
    int   b;
    o.status        = ST_OK;
    o.granted_block = '0;
    found           = 1'b0;
    if (r.req_type == REQ_ALLOC) begin
      // First fit: lowest word with a free bit, then its lowest free bit.
      for (w = 0; w < MAP_WORDS && !found; w++) begin
        if (shadow_words[w] != '0) begin
          for (b = 0; b < WORD_BITS && !found; b++) begin
            if (shadow_words[w][b]) begin
              shadow_words[w][b] = 1'b0;
              o.granted_block = BLK_W'(w * WORD_BITS + b);
              found = 1'b1;
            end
          end
        end
      end
      if (!found) o.status = ST_FULL;
    end else if (int'(r.block_number) >= NUM_BLOCKS) begin
      o.status = ST_RANGE;
    end else begin
      // A release sets the bit; releasing a free block leaves it free.
      w = r.block_number / WORD_BITS;
      b = r.block_number % WORD_BITS;
      shadow_words[w][b] = 1'b1;
    end
    return o;
  endfunction

  // Offer one request after a random gap and hold it until the transfer.
  // Valid stays high afterwards so back-to-back requests need no extra edge.
  task automatic send_request(input logic kind, input logic [BLK_W-1:0] blk);
    int   gap;
    req_t item;
    rsp_t reply;
    gap = idle_length();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item.req_type     = kind;
    item.block_number = blk;
    reply = serve_request(item);
    owed_replies.push_back(reply);
    if (kind == REQ_RELEASE) releases++;
    else if (reply.status == ST_OK) grants++;
    else full_replies++;
    req       <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  // Drop valid and wait until every reply owed so far has arrived.
  task automatic wait_drained();
    req_valid <= 1'b0;
    while (owed_replies.size() != 0) @(posedge clk);
  endtask

  // Reply stall: runs of stall and no stall with random lengths.
  int  stall_left = 0;
  bit  stall_on = 1'b0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_on   = ($urandom_range(0, 1) == 1);
      stall_left = stall_on ? idle_length() + 1 : $urandom_range(1, 8);
    end
    stall_left--;
    rsp_stall <= stall_on;
  end

  // Reply checker: every transfer is compared with the oldest owed reply.
  always @(posedge clk) begin
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (owed_replies.size() == 0) begin
        $display("%0t: reply with none owed, got status %0d block %0d",
                 $time, rsp.status, rsp.granted_block);
        errors++;
      end else begin
        want = owed_replies.pop_front();
        if (rsp.status !== want.status) begin
          $display("%0t: status mismatch, expected %0d, got %0d",
                   $time, want.status, rsp.status);
          errors++;
        end
        if (rsp.granted_block !== want.granted_block) begin
          $display("%0t: granted_block mismatch, expected %0d, got %0d",
                   $time, want.granted_block, rsp.granted_block);
          errors++;
        end
      end
    end
  end

  // Watchdog: too long without a transfer on either channel means a hang.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= HANG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, HANG_LIMIT);
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Reset contents, reserved blocks, ignored block number on allocate,
  // releases of free blocks and the extremes of the block number.
  task automatic test_directed();
    send_request(REQ_ALLOC, '1);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, 13'h0AAA);
    send_request(REQ_RELEASE, '0);
    send_request(REQ_ALLOC, 13'h1555);
    send_request(REQ_RELEASE, BLK_W'(RESERVED_BLOCKS - 1));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_RELEASE, BLK_W'(RESERVED_BLOCKS + 1));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_RELEASE, 13'd5000);
    send_request(REQ_RELEASE, 13'd5000);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_RELEASE, '1);
    send_request(REQ_RELEASE, BLK_W'(WORD_BITS - 1));
    send_request(REQ_RELEASE, BLK_W'(WORD_BITS));
    send_request(REQ_RELEASE, BLK_W'(RESERVED_BLOCKS));
    send_request(REQ_ALLOC, '0);
    send_request(REQ_RELEASE, '0);
    send_request(REQ_RELEASE, '0);
    send_request(REQ_ALLOC, '0);
    send_request(REQ_ALLOC, '1);
    wait_drained();
  endtask

  // Random traffic on a mostly free map; releases mostly hit the low,
  // recently granted blocks, the rest land anywhere.
  task automatic test_sparse_traffic();
    for (int i = 0; i < SPARSE_REQS; i++) begin
      if ($urandom_range(0, 99) < 55)
        send_request(REQ_ALLOC, BLK_W'($urandom));
      else if ($urandom_range(0, 9) < 7)
        send_request(REQ_RELEASE, BLK_W'($urandom_range(0, 4 * WORD_BITS - 1)));
      else
        send_request(REQ_RELEASE, BLK_W'($urandom));
    end
    wait_drained();
  endtask

  // Random traffic where allocations outnumber releases, so the granted
  // range keeps growing past the first words of the map.
  task automatic test_alloc_heavy_traffic();
    for (int i = 0; i < CHURN_REQS; i++) begin
      if ($urandom_range(0, 99) < 60)
        send_request(REQ_ALLOC, BLK_W'($urandom));
      else
        send_request(REQ_RELEASE, BLK_W'($urandom));
    end
    wait_drained();
  endtask

  initial begin
    clear_shadow();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_sparse_traffic();
    test_alloc_heavy_traffic();
    repeat (SETTLE_CYC) @(posedge clk);
    $display("Sent %0d requests: %0d blocks granted, %0d full-map replies, %0d releases.",
             grants + full_replies + releases, grants, full_replies, releases);
    $display("Traffic ran from a fresh map with random gaps and reply stalls.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
